/* rtl/sha1_stream_hash_top_assert.svh */
// assertion macros shared by the sha1 stream hash modules
`ifndef SHA1_STREAM_HASH_TOP_ASSERT_SVH
`define SHA1_STREAM_HASH_TOP_ASSERT_SVH

// same-cycle implication
`define SHA1SH_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("sha1 stream hash check failed");

// next-cycle implication
`define SHA1SH_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("sha1 stream hash check failed");

`endif

/* rtl/sha1sh_pkg.sv */
`default_nettype none

package sha1sh_pkg;

  localparam int BLOCK_WORDS  = 16;
  localparam int DIGEST_WORDS = 5;

  localparam logic [5:0] FILL_LAST   = 6'd63;
  localparam logic [5:0] FILL_LEN    = 6'd56;
  localparam logic [6:0] LAST_ROUND  = 7'd79;
  localparam logic [2:0] LAST_IDX    = 3'd4;
  localparam logic [7:0] PAD_MARK    = 8'h80;

  // byte source for a block write
  localparam logic [1:0] SRC_DATA = 2'd0;
  localparam logic [1:0] SRC_MARK = 2'd1;
  localparam logic [1:0] SRC_ZERO = 2'd2;
  localparam logic [1:0] SRC_LEN  = 2'd3;

  typedef struct packed {
    logic       push;
    logic [1:0] src;
    logic       load_work;
    logic       round;
    logic [6:0] rnd;
    logic       add;
    logic       load_out;
    logic [2:0] out_idx;
    logic       new_msg;
  } cmd_t;

  typedef struct packed {
    logic fill_last;
    logic fill_len;
    logic out_free;
  } stat_t;

  function automatic logic [31:0] iv_word(input logic [2:0] i);
    logic [31:0] v;
    case (i)
      3'd0:    v = 32'h67452301;
      3'd1:    v = 32'hEFCDAB89;
      3'd2:    v = 32'h98BADCFE;
      3'd3:    v = 32'h10325476;
      default: v = 32'hC3D2E1F0;
    endcase
    return v;
  endfunction

  function automatic logic [31:0] round_const(input logic [6:0] t);
    logic [31:0] k;
    if (t < 7'd20) begin
      k = 32'h5A827999;
    end else if (t < 7'd40) begin
      k = 32'h6ED9EBA1;
    end else if (t < 7'd60) begin
      k = 32'h8F1BBCDC;
    end else begin
      k = 32'hCA62C1D6;
    end
    return k;
  endfunction

endpackage

`default_nettype wire

/* rtl/sha1sh_if.sv */
`default_nettype none

interface sha1sh_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] msg_byte;
  logic       byte_present;
  logic       end_of_message;

  modport source (output valid, output msg_byte, output byte_present,
                  output end_of_message, input ready);
  modport sink (input valid, input msg_byte, input byte_present,
                input end_of_message, output ready);
endinterface

interface sha1sh_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] digest_word;
  logic [2:0]  word_index;
  logic        last_word;

  modport source (output valid, output digest_word, output word_index,
                  output last_word, input ready);
  modport sink (input valid, input digest_word, input word_index,
                input last_word, output ready);
endinterface

`default_nettype wire

/* rtl/sha1sh_dp.sv */
`default_nettype none
`include "sha1_stream_hash_top_assert.svh"

module sha1sh_dp (
  input  logic               clk,
  input  logic               rst,
  input  sha1sh_pkg::cmd_t   cmd,
  output sha1sh_pkg::stat_t  stat,
  input  logic [7:0]         msg_byte,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [31:0]        digest_word,
  output logic [2:0]         word_index,
  output logic               last_word
);

  logic [31:0] sched [sha1sh_pkg::BLOCK_WORDS];
  logic [31:0] chain [sha1sh_pkg::DIGEST_WORDS];
  logic [31:0] a, b, c, d, e;
  logic [5:0]  fill;
  logic [60:0] byte_total;

  logic [63:0] bit_count;
  logic [63:0] len_shift;
  logic [7:0]  len_byte;
  logic [7:0]  push_byte;
  logic [31:0] mix;
  logic [31:0] new_w;
  logic [31:0] f;
  logic [31:0] t;

  // length bytes go out most significant first
  assign bit_count = {byte_total, 3'b000};
  assign len_shift = bit_count >> {~fill[2:0], 3'b000};
  assign len_byte  = len_shift[7:0];

  always_comb begin
    unique case (cmd.src)
      sha1sh_pkg::SRC_DATA: push_byte = msg_byte;
      sha1sh_pkg::SRC_MARK: push_byte = sha1sh_pkg::PAD_MARK;
      sha1sh_pkg::SRC_ZERO: push_byte = 8'h00;
      default:              push_byte = len_byte;
    endcase
  end

  // message schedule: w[t+16] from a 16-word window
  assign mix   = sched[13] ^ sched[8] ^ sched[2] ^ sched[0];
  assign new_w = {mix[30:0], mix[31]};

  always_comb begin
    if (cmd.rnd < 7'd20) begin
      f = (b & c) | (~b & d);
    end else if (cmd.rnd < 7'd40) begin
      f = b ^ c ^ d;
    end else if (cmd.rnd < 7'd60) begin
      f = (b & c) | (b & d) | (c & d);
    end else begin
      f = b ^ c ^ d;
    end
  end

  assign t = {a[26:0], a[31:27]} + f + e + sha1sh_pkg::round_const(cmd.rnd) + sched[0];

  // block bytes shift in big-endian, rounds shift whole words
  always_ff @(posedge clk) begin
    if (cmd.push) begin
      for (int i = 0; i < sha1sh_pkg::BLOCK_WORDS - 1; i++) begin
        sched[i] <= {sched[i][23:0], sched[i+1][31:24]};
      end
      sched[sha1sh_pkg::BLOCK_WORDS-1] <=
        {sched[sha1sh_pkg::BLOCK_WORDS-1][23:0], push_byte};
    end else if (cmd.round) begin
      for (int i = 0; i < sha1sh_pkg::BLOCK_WORDS - 1; i++) begin
        sched[i] <= sched[i+1];
      end
      sched[sha1sh_pkg::BLOCK_WORDS-1] <= new_w;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_work) begin
      a <= chain[0];
      b <= chain[1];
      c <= chain[2];
      d <= chain[3];
      e <= chain[4];
    end else if (cmd.round) begin
      a <= t;
      b <= a;
      c <= {b[1:0], b[31:2]};
      d <= c;
      e <= d;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.new_msg) begin
      for (int i = 0; i < sha1sh_pkg::DIGEST_WORDS; i++) begin
        chain[i] <= sha1sh_pkg::iv_word(3'(i));
      end
    end else if (cmd.add) begin
      chain[0] <= chain[0] + a;
      chain[1] <= chain[1] + b;
      chain[2] <= chain[2] + c;
      chain[3] <= chain[3] + d;
      chain[4] <= chain[4] + e;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.new_msg) begin
      fill       <= '0;
      byte_total <= '0;
    end else if (cmd.push) begin
      fill <= fill + 6'd1;
      if (cmd.src == sha1sh_pkg::SRC_DATA) begin
        byte_total <= byte_total + 61'd1;
      end
    end
  end

  // output register, one digest word per transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      digest_word <= chain[cmd.out_idx];
      word_index  <= cmd.out_idx;
      last_word   <= (cmd.out_idx == sha1sh_pkg::LAST_IDX);
    end
  end

  assign stat.fill_last = (fill == sha1sh_pkg::FILL_LAST);
  assign stat.fill_len  = (fill == sha1sh_pkg::FILL_LEN);
  assign stat.out_free  = !out_valid || out_ready;

  `SHA1SH_ASSERT_NEXT(a_block_wraps, clk, rst, cmd.load_work, fill == 6'd0)
  `SHA1SH_ASSERT_NEXT(a_msg_cleared, clk, rst, cmd.new_msg, byte_total == 61'd0 && fill == 6'd0)

endmodule

`default_nettype wire

/* rtl/sha1sh_ctrl.sv */
`default_nettype none
`include "sha1_stream_hash_top_assert.svh"

module sha1sh_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic              in_present,
  input  logic              in_end,
  output logic              in_ready,
  input  sha1sh_pkg::stat_t stat,
  output sha1sh_pkg::cmd_t  cmd
);

  localparam logic [2:0] S_ACCEPT = 3'd0;
  localparam logic [2:0] S_ROUND  = 3'd1;
  localparam logic [2:0] S_ADD    = 3'd2;
  localparam logic [2:0] S_PAD    = 3'd3;
  localparam logic [2:0] S_OUT    = 3'd4;

  logic [2:0] state;
  logic [6:0] rnd;
  logic [2:0] idx;
  logic       pad_active;
  logic       marker_done;
  logic       len_phase;
  logic       final_blk;

  logic       xfer;
  logic [1:0] pad_src;

  assign in_ready = (state == S_ACCEPT);
  assign xfer     = in_ready && in_valid;

  always_comb begin
    if (!marker_done) begin
      pad_src = sha1sh_pkg::SRC_MARK;
    end else if (len_phase || stat.fill_len) begin
      pad_src = sha1sh_pkg::SRC_LEN;
    end else begin
      pad_src = sha1sh_pkg::SRC_ZERO;
    end
  end

  always_comb begin
    cmd = '0;
    unique case (state)
      S_ACCEPT: begin
        cmd.push      = xfer && in_present;
        cmd.src       = sha1sh_pkg::SRC_DATA;
        cmd.load_work = xfer && in_present && stat.fill_last;
      end
      S_ROUND: begin
        cmd.round = 1'b1;
        cmd.rnd   = rnd;
      end
      S_ADD: begin
        cmd.add = 1'b1;
      end
      S_PAD: begin
        cmd.push      = 1'b1;
        cmd.src       = pad_src;
        cmd.load_work = stat.fill_last;
      end
      S_OUT: begin
        cmd.load_out = stat.out_free;
        cmd.out_idx  = idx;
        cmd.new_msg  = stat.out_free && (idx == sha1sh_pkg::LAST_IDX);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_ACCEPT;
      rnd         <= '0;
      idx         <= '0;
      pad_active  <= 1'b0;
      marker_done <= 1'b0;
      len_phase   <= 1'b0;
      final_blk   <= 1'b0;
    end else begin
      unique case (state)
        S_ACCEPT: begin
          if (xfer) begin
            if (in_present && stat.fill_last) begin
              state      <= S_ROUND;
              pad_active <= in_end;
            end else if (in_end) begin
              state      <= S_PAD;
              pad_active <= 1'b1;
            end
          end
        end
        S_ROUND: begin
          if (rnd == sha1sh_pkg::LAST_ROUND) begin
            rnd   <= '0;
            state <= S_ADD;
          end else begin
            rnd <= rnd + 7'd1;
          end
        end
        S_ADD: begin
          if (final_blk) begin
            state <= S_OUT;
            idx   <= '0;
          end else if (pad_active) begin
            state <= S_PAD;
          end else begin
            state <= S_ACCEPT;
          end
        end
        S_PAD: begin
          marker_done <= 1'b1;
          if (pad_src == sha1sh_pkg::SRC_LEN) begin
            len_phase <= 1'b1;
          end
          if (stat.fill_last) begin
            state <= S_ROUND;
            if (pad_src == sha1sh_pkg::SRC_LEN) begin
              final_blk <= 1'b1;
            end
          end
        end
        S_OUT: begin
          if (stat.out_free) begin
            if (idx == sha1sh_pkg::LAST_IDX) begin
              state       <= S_ACCEPT;
              idx         <= '0;
              pad_active  <= 1'b0;
              marker_done <= 1'b0;
              len_phase   <= 1'b0;
              final_blk   <= 1'b0;
            end else begin
              idx <= idx + 3'd1;
            end
          end
        end
        default: begin
          state <= S_ACCEPT;
        end
      endcase
    end
  end

  `SHA1SH_ASSERT_NEXT(a_round_to_add, clk, rst, state == S_ROUND && rnd == sha1sh_pkg::LAST_ROUND, state == S_ADD)
  `SHA1SH_ASSERT_NEXT(a_msg_done, clk, rst, cmd.new_msg, state == S_ACCEPT && !pad_active && !final_blk)
  `SHA1SH_ASSERT_IMPL(a_push_states, clk, rst, cmd.push, state == S_ACCEPT || state == S_PAD)

endmodule

`default_nettype wire

/* rtl/sha1_stream_hash_top.sv */
// SHA-1 over a byte stream. Each transfer on msg carries one byte (used when
// byte_present is 1) and an end_of_message flag; the end item's own byte is
// hashed before padding. A message ending gives five transfers on digest,
// word_index 0 to 4, last_word on the fifth, after which a new message starts
// from the initial vector. Every full 64-byte block holds msg.ready low through
// 80 rounds on one shared round unit plus the chaining add. Padding writes one
// byte per cycle into the same block register, pausing while a block compresses,
// and may compress one extra block; the digest words leave through an output
// register that lets the next message start while the last word waits.
`default_nettype none

module sha1_stream_hash_top (
  input  logic         clk,
  input  logic         rst,
  sha1sh_in_if.sink    msg,
  sha1sh_out_if.source digest
);

  sha1sh_pkg::cmd_t  cmd;
  sha1sh_pkg::stat_t stat;

  sha1sh_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (msg.valid),
    .in_present (msg.byte_present),
    .in_end     (msg.end_of_message),
    .in_ready   (msg.ready),
    .stat       (stat),
    .cmd        (cmd)
  );

  sha1sh_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .stat        (stat),
    .msg_byte    (msg.msg_byte),
    .out_valid   (digest.valid),
    .out_ready   (digest.ready),
    .digest_word (digest.digest_word),
    .word_index  (digest.word_index),
    .last_word   (digest.last_word)
  );

endmodule

`default_nettype wire

/* tb/tb_sha1_stream_hash_top.sv */
`default_nettype none

module tb_sha1_stream_hash_top;

  localparam int CYCLE_LIMIT = 1000000;
  localparam int DRAIN_CYCLES = 40;

  localparam logic [31:0] SHA1_IV [5] = '{
    32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
  };
  localparam logic [31:0] SHA1_K [4] = '{
    32'h5A827999, 32'h6ED9EBA1, 32'h8F1BBCDC, 32'hCA62C1D6
  };

  typedef struct packed {
    logic [31:0] word;
    logic [2:0]  idx;
    logic        last;
  } digest_beat_t;

  logic clk;
  logic rst;

  sha1sh_in_if  msg_if ();
  sha1sh_out_if dig_if ();

  sha1_stream_hash_top dut (
    .clk    (clk),
    .rst    (rst),
    .msg    (msg_if),
    .digest (dig_if)
  );

  // hash state mirror
  logic [31:0] chain [5];
  logic [31:0] blk [16];
  logic [5:0]  fill;
  logic [60:0] total;

  digest_beat_t digest_q [$];

  int error_count;
  int cycle_cnt;
  int items_sent;
  int bytes_sent;
  int msgs_done;
  int words_checked;
  int burst_left;
  bit gaps_on;
  int hold_len;
  int hold_req;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic logic [31:0] rotl32(input logic [31:0] x, input int s);
    return (x << s) | (x >> (32 - s));
  endfunction

  function automatic void sha1_reset();
    for (int i = 0; i < 5; i++) chain[i] = SHA1_IV[i];
    for (int i = 0; i < 16; i++) blk[i] = '0;
    fill = '0;
    total = '0;
  endfunction

  function automatic void sha1_compress();
    logic [31:0] w [80];
    logic [31:0] a, b, c, d, e, f, k, t;
    for (int i = 0; i < 16; i++) w[i] = blk[i];
    for (int i = 16; i < 80; i++) w[i] = rotl32(w[i-3] ^ w[i-8] ^ w[i-14] ^ w[i-16], 1);
    a = chain[0];
    b = chain[1];
    c = chain[2];
    d = chain[3];
    e = chain[4];
    for (int i = 0; i < 80; i++) begin
      if (i < 20) begin
        f = (b & c) | (~b & d);
        k = SHA1_K[0];
      end else if (i < 40) begin
        f = b ^ c ^ d;
        k = SHA1_K[1];
      end else if (i < 60) begin
        f = (b & c) | (b & d) | (c & d);
        k = SHA1_K[2];
      end else begin
        f = b ^ c ^ d;
        k = SHA1_K[3];
      end
      t = rotl32(a, 5) + f + e + k + w[i];
      e = d;
      d = c;
      c = rotl32(b, 30);
      b = a;
      a = t;
    end
    chain[0] += a;
    chain[1] += b;
    chain[2] += c;
    chain[3] += d;
    chain[4] += e;
  endfunction

  function automatic void sha1_push(input logic [7:0] b);
    blk[fill[5:2]][8 * (3 - fill[1:0]) +: 8] = b;
    fill = fill + 6'd1;
    if (fill == 6'd0) sha1_compress();
  endfunction

  // advance the mirror by one accepted transfer, queue digest words on end
  function automatic void sha1_absorb(input logic [7:0] b, input logic present,
                                      input logic eom);
    logic [63:0] bit_len;
    digest_beat_t beat;
    if (present) begin
      total = total + 61'd1;
      sha1_push(b);
    end
    if (!eom) return;
    bit_len = {total, 3'b000};
    sha1_push(sha1sh_pkg::PAD_MARK);
    while (fill != sha1sh_pkg::FILL_LEN) sha1_push(8'h00);
    for (int i = 0; i < 8; i++) sha1_push(bit_len[63 - 8 * i -: 8]);
    for (int i = 0; i < sha1sh_pkg::DIGEST_WORDS; i++) begin
      beat.word = chain[i];
      beat.idx  = 3'(i);
      beat.last = (beat.idx == sha1sh_pkg::LAST_IDX);
      digest_q.push_back(beat);
    end
    for (int i = 0; i < 5; i++) chain[i] = SHA1_IV[i];
    fill = '0;
    total = '0;
  endfunction

  // one transfer on msg, with bursty gaps
  task automatic send_item(input logic [7:0] b, input logic present, input logic eom);
    int gap;
    if (burst_left == 0) begin
      gap = gaps_on ? $urandom_range(0, 7) : 0;
      if (gap > 0) begin
        msg_if.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 16);
    end
    msg_if.valid          <= 1'b1;
    msg_if.msg_byte       <= b;
    msg_if.byte_present   <= present;
    msg_if.end_of_message <= eom;
    do @(posedge clk); while (!msg_if.ready);
    sha1_absorb(b, present, eom);
    burst_left--;
    items_sent++;
    if (present) bytes_sent++;
    if (eom) msgs_done++;
  endtask

  task automatic sender_idle();
    msg_if.valid <= 1'b0;
    burst_left = 0;
  endtask

  task automatic wait_digests_done();
    do @(posedge clk); while (digest_q.size() != 0);
  endtask

  task automatic send_message(input int len, input bit empty_end, input int noise_pct);
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(0, 99) < noise_pct) send_item(8'($urandom), 1'b0, 1'b0);
      send_item(8'($urandom), 1'b1, (i == len - 1) && !empty_end);
    end
    if (empty_end || len == 0) send_item(8'($urandom), 1'b0, 1'b1);
  endtask

  task automatic test_directed();
    // empty message
    send_item(8'h00, 1'b0, 1'b1);
    // "abc", ending on a data byte, with a no-op item inside
    send_item(8'h61, 1'b1, 1'b0);
    send_item(8'hFF, 1'b0, 1'b0);
    send_item(8'h62, 1'b1, 1'b0);
    send_item(8'h63, 1'b1, 1'b1);
    // single byte extremes
    send_item(8'hFF, 1'b1, 1'b1);
    send_item(8'h00, 1'b1, 1'b1);
    // data then empty end marker carrying a junk byte
    send_item(8'hA5, 1'b1, 1'b0);
    send_item(8'h5A, 1'b1, 1'b0);
    send_item(8'hFF, 1'b0, 1'b1);
    // no-op before an empty message
    send_item(8'h00, 1'b0, 1'b0);
    send_item(8'h80, 1'b0, 1'b1);
  endtask

  task automatic test_pad_boundaries();
    // lengths around the length field at byte 56 and the block edge
    send_message(55, 1'b0, 0);
    send_message(56, 1'b1, 0);
    send_message(63, 1'b0, 0);
    send_message(64, 1'b0, 0);
  endtask

  task automatic test_output_stall();
    hold_len = 1500;
    hold_req++;
    gaps_on = 1'b0;
    for (int m = 0; m < 4; m++) send_message($urandom_range(1, 8), 1'b0, 0);
    gaps_on = 1'b1;
  endtask

  task automatic test_drain_pause();
    for (int m = 0; m < 4; m++) begin
      send_message($urandom_range(0, 20), 1'($urandom_range(0, 1)), 10);
      sender_idle();
      wait_digests_done();
    end
  endtask

  task automatic test_random_messages();
    int start;
    int sel;
    int len;
    start = items_sent;
    while (items_sent - start < 100) begin
      sel = $urandom_range(0, 99);
      if (sel < 80) len = $urandom_range(0, 24);
      else if (sel < 95) len = $urandom_range(25, 70);
      else len = $urandom_range(71, 100);
      gaps_on = ($urandom_range(0, 3) != 0);
      send_message(len, ($urandom_range(0, 4) == 0), 8);
    end
    gaps_on = 1'b1;
  endtask

  // receiver: long hold on request, otherwise a rotating stall pattern
  initial begin
    int hold_seen;
    int hold_left;
    logic [31:0] pat_cnt;
    hold_seen = 0;
    hold_left = 0;
    pat_cnt = '0;
    dig_if.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_seen != hold_req) begin
        hold_seen = hold_req;
        hold_left = hold_len;
      end
      if (hold_left > 0) begin
        hold_left--;
        dig_if.ready <= 1'b0;
      end else begin
        pat_cnt++;
        case (pat_cnt[9:8])
          2'd0: dig_if.ready <= 1'b1;
          2'd1: dig_if.ready <= ($urandom_range(0, 1) == 1);
          2'd2: dig_if.ready <= ($urandom_range(0, 5) == 0);
          default: dig_if.ready <= (pat_cnt[2:0] != 3'd0);
        endcase
      end
    end
  end

  // digest checker
  always @(posedge clk) begin
    digest_beat_t exp_beat;
    if (!rst && dig_if.valid && dig_if.ready) begin
      if (digest_q.size() == 0) begin
        $error("unexpected digest transfer: word %h index %0d last %0b",
               dig_if.digest_word, dig_if.word_index, dig_if.last_word);
        error_count++;
      end else begin
        exp_beat = digest_q.pop_front();
        words_checked++;
        if (dig_if.digest_word !== exp_beat.word) begin
          $error("digest_word: expected %h, actual %h", exp_beat.word, dig_if.digest_word);
          error_count++;
        end
        if (dig_if.word_index !== exp_beat.idx) begin
          $error("word_index: expected %0d, actual %0d", exp_beat.idx, dig_if.word_index);
          error_count++;
        end
        if (dig_if.last_word !== exp_beat.last) begin
          $error("last_word: expected %0b, actual %0b", exp_beat.last, dig_if.last_word);
          error_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d digest words outstanding",
               cycle_cnt, digest_q.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    error_count = 0;
    cycle_cnt = 0;
    items_sent = 0;
    bytes_sent = 0;
    msgs_done = 0;
    words_checked = 0;
    burst_left = 0;
    gaps_on = 1'b1;
    hold_len = 0;
    hold_req = 0;
    sha1_reset();
    rst = 1'b1;
    msg_if.valid = 1'b0;
    msg_if.msg_byte = '0;
    msg_if.byte_present = 1'b0;
    msg_if.end_of_message = 1'b0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    test_directed();
    test_pad_boundaries();
    test_output_stall();
    test_drain_pause();
    test_random_messages();

    sender_idle();
    wait_digests_done();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("hashed %0d messages (%0d bytes, %0d transfers) incl. padding edges",
             msgs_done, bytes_sent, items_sent);
    $display("checked %0d digest words under output stalls and input gaps", words_checked);
    if (error_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

`default_nettype wire
